/* rtl/asul_pkg.sv */
package asul_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 16;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;
    localparam logic [BYTE_W-1:0] LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CSI_FINAL_LO = 8'h40;
    localparam logic [BYTE_W-1:0] CSI_FINAL_HI = 8'h7E;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One queued item: a held ESC to send, a kept byte to send, and the end mark.
    typedef struct packed {
        logic              esc;
        logic              keep;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_op;

    function automatic logic [1:0] lead_skip(input logic [BYTE_W-1:0] b);
        logic [1:0] s;
        s = 2'd0;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            s = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            s = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            s = 2'd3;
        end
        return s;
    endfunction

endpackage

/* rtl/asul_front.sv */
module asul_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [asul_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                           i_end_of_text,
    input  logic                           i_full,
    output logic                           o_push,
    output asul_pkg::t_op                  o_op
);
    import asul_pkg::*;

    logic r_in_csi;
    logic r_esc_pend;
    logic n_in_csi;
    logic n_esc_pend;
    logic esc;
    logic keep;
    logic accept;

    assign o_ready = !i_full;
    assign accept = i_valid && o_ready;

    always_comb begin
        esc = 1'b0;
        keep = 1'b0;
        n_in_csi = r_in_csi;
        n_esc_pend = 1'b0;
        if (r_in_csi) begin
            if (i_in_byte >= CSI_FINAL_LO && i_in_byte <= CSI_FINAL_HI) begin
                n_in_csi = 1'b0;
            end
        end else if (r_esc_pend && i_in_byte == LBRACKET) begin
            n_in_csi = 1'b1;
        end else begin
            esc = r_esc_pend;
            if (i_in_byte == ESC_BYTE && !i_end_of_text) begin
                n_esc_pend = 1'b1;
            end else begin
                keep = 1'b1;
            end
        end
        if (i_end_of_text) begin
            n_in_csi = 1'b0;
            n_esc_pend = 1'b0;
        end
    end

    assign o_op.esc = esc;
    assign o_op.keep = keep;
    assign o_op.data = i_in_byte;
    assign o_op.last = i_end_of_text;
    assign o_push = accept && (esc || keep || i_end_of_text);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_csi <= 1'b0;
            r_esc_pend <= 1'b0;
        end else if (accept) begin
            r_in_csi <= n_in_csi;
            r_esc_pend <= n_esc_pend;
        end
    end

endmodule

/* rtl/asul_queue.sv */
module asul_queue #(
    parameter int DEPTH = asul_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  asul_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output asul_pkg::t_op o_op
);
    import asul_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_op = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/asul_back.sv */
module asul_back #(
    parameter int COUNT_BITS = asul_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  asul_pkg::t_op                 i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [asul_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [asul_pkg::LEN_W-1:0]    o_visual_length,
    output logic                          o_last_result
);
    import asul_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX =
        (COUNT_BITS > LEN_W) ? COUNT_BITS'(16'hFFFF) : '1;

    logic                  r_esc_done;
    logic                  r_byte_done;
    logic [1:0]            r_skip;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_valid;
    logic                  r_kind;
    logic [BYTE_W-1:0]     r_byte;
    logic [LEN_W-1:0]      r_len;
    logic                  r_last;

    logic                  need_esc;
    logic                  need_byte;
    logic                  cur_esc;
    logic                  cur_byte;
    logic                  cur_sum;
    logic                  final_res;
    logic                  fire;
    logic [BYTE_W-1:0]     cur_data;
    logic [1:0]            n_skip;
    logic [COUNT_BITS-1:0] n_count;

    assign need_esc = i_head.esc && !r_esc_done;
    assign need_byte = i_head.keep && !r_byte_done;
    assign cur_esc = need_esc;
    assign cur_byte = !need_esc && need_byte;
    assign cur_sum = !need_esc && !need_byte;
    assign final_res = (cur_esc && !i_head.keep && !i_head.last)
                    || (cur_byte && !i_head.last) || cur_sum;
    assign cur_data = cur_esc ? ESC_BYTE : i_head.data;

    assign fire = i_head_valid && (!r_valid || i_ready);
    assign o_pop = fire && final_res;

    always_comb begin
        n_skip = r_skip;
        n_count = r_count;
        if (cur_sum) begin
            n_skip = 2'd0;
            n_count = '0;
        end else if (r_skip != 2'd0) begin
            n_skip = r_skip - 2'd1;
        end else begin
            n_skip = lead_skip(cur_data);
            if (r_count != CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_done <= 1'b0;
            r_byte_done <= 1'b0;
            r_skip <= 2'd0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_skip <= n_skip;
                r_count <= n_count;
                if (final_res) begin
                    r_esc_done <= 1'b0;
                    r_byte_done <= 1'b0;
                end else if (cur_esc) begin
                    r_esc_done <= 1'b1;
                end else begin
                    r_byte_done <= 1'b1;
                end
            end
            if (fire) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind <= cur_sum ? KIND_SUMMARY : KIND_BYTE;
            r_byte <= cur_sum ? '0 : cur_data;
            r_len <= cur_sum ? LEN_W'(r_count) : '0;
            r_last <= cur_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_out_byte = r_byte;
    assign o_visual_length = r_len;
    assign o_last_result = r_last;

endmodule

/* rtl/ansi_strip_utf8_length.sv */
// Removes ANSI CSI escape sequences (ESC '[' up to a final byte 0x40..0x7E) from a byte
// stream, passes every kept byte on, and after the byte marked end_of_text sends one
// summary transfer carrying the UTF-8 character count of the kept text, saturating at
// the smaller of 2^COUNT_BITS-1 and 65535. Input transfers are taken one per cycle while
// the internal queue has room. The output stage sends one result per cycle while i_ready
// permits; a dropped byte yields no result, a kept byte one, and a byte that releases a
// held ESC or ends the text yields up to three; the queue of QUEUE_DEPTH entries absorbs
// these bursts. Each result is registered in the queue and again in the output stage.
// The block holds no state across texts.
module ansi_strip_utf8_length #(
    parameter int COUNT_BITS = asul_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = asul_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [asul_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_end_of_text,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [asul_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [asul_pkg::LEN_W-1:0]    o_visual_length,
    output logic                          o_last_result
);
    import asul_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic nonempty;
    t_op  in_op;
    t_op  head_op;

    asul_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (full),
        .o_push        (push),
        .o_op          (in_op)
    );

    asul_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_op       (in_op),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_op       (head_op)
    );

    asul_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (nonempty),
        .i_head          (head_op),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_visual_length (o_visual_length),
        .o_last_result   (o_last_result)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && !nonempty))
        else $error("Queue read while empty.");

    a_summary_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_SUMMARY) |-> (o_out_byte == '0 && o_last_result))
        else $error("Summary transfer has a byte or lacks the last mark.");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_BYTE) |-> (o_visual_length == '0 && !o_last_result))
        else $error("Byte transfer carries a length or the last mark.");

endmodule
